FILE: rtl/bezier_ease_y_from_x_unit_defines.svh
// Assertion macros for the bezier ease unit checker.
// No dependencies.
`ifndef BEZIER_EASE_Y_FROM_X_UNIT_DEFINES_SVH
`define BEZIER_EASE_Y_FROM_X_UNIT_DEFINES_SVH

// clocked assertion, off while reset is high
`define BEZ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion, also checked during reset
`define BEZ_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/bez_pkg.sv
// Package for the bezier ease unit: widths, word types, fixed-point helpers.
// No dependencies.
package bez_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FIELD_W   = FRAC_BITS + 1;
   localparam int Q_W       = FRAC_BITS + 4;
   localparam int SAT_W     = 2 * Q_W;
   localparam int MAX_ITER  = 31;
   localparam int ITER_W    = 5;
   localparam int TOL_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = CSR_IDX_W'(1);

   localparam logic [ITER_W-1:0] ITER_LIMIT_RST = ITER_W'(12);
   localparam logic [TOL_W-1:0]  TOLERANCE_RST  = TOL_W'(33);

   localparam logic [FIELD_W-1:0] ONE_U = FIELD_W'(1) << FRAC_BITS;
   localparam logic signed [SAT_W-1:0] ONE_W = SAT_W'(1) << FRAC_BITS;
   localparam logic signed [SAT_W-1:0] Q_MAX_W = (SAT_W'(1) <<< (Q_W - 1)) - SAT_W'(1);
   localparam logic signed [SAT_W-1:0] Q_MIN_W = -(SAT_W'(1) <<< (Q_W - 1));

   typedef struct packed {
      logic [FIELD_W-1:0] x_in;
      logic [FIELD_W-1:0] ctrl1_x;
      logic [FIELD_W-1:0] ctrl1_y;
      logic [FIELD_W-1:0] ctrl2_x;
      logic [FIELD_W-1:0] ctrl2_y;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_W-1:0] y_out;
      logic               converged;
   } rsp_word_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] r;
      r = v;
      if (v > Q_MAX_W) r = Q_MAX_W;
      if (v < Q_MIN_W) r = Q_MIN_W;
      return r[Q_W-1:0];
   endfunction

   // product floored by 2^FRAC_BITS, then saturated
   function automatic logic signed [Q_W-1:0] mul_q(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
      logic signed [SAT_W-1:0] p;
      p = SAT_W'(a) * SAT_W'(b);
      return sat_q(p >>> FRAC_BITS);
   endfunction

   function automatic logic [FIELD_W-1:0] clamp_unit(input logic [FIELD_W-1:0] v);
      return (v > ONE_U) ? ONE_U : v;
   endfunction

endpackage

FILE: rtl/bezier_ease_y_from_x_unit.sv
// Top level of the bezier ease unit: y from x on a cubic easing curve.
// Depends on bez_pkg.
//
//   channel  dir  handshake              payload
//   req_     in   req_valid / req_ready  req_word  (bez_pkg::req_word_type)
//   rsp_     out  rsp_valid / rsp_ready  rsp_word  (bez_pkg::rsp_word_type)
//   csr_     in   csr_write              csr_index, csr_data
//
// Fully pipelined: one word enters per cycle while the output is not stalled, through
// 1 + 3*MAX_ITER + 7 = 101 register stages.
// Each refinement takes three stages (one multiplier each); stages past the limit
// or after convergence pass the word through unchanged.
// Reset is synchronous; it clears the valid bits and reloads the iteration limit and tolerance registers.
// A stalled output stalls the whole pipe; nothing is dropped or repeated.
module bezier_ease_y_from_x_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bez_pkg::req_word_type         req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bez_pkg::rsp_word_type         rsp_word,
   input  logic                          csr_write,
   input  logic [bez_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bez_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int IT_END  = 3 * bez_pkg::MAX_ITER;
   localparam int Y_STG   = 7;
   localparam int LAST    = IT_END + Y_STG;
   localparam int Q_W     = bez_pkg::Q_W;
   localparam int SAT_W   = bez_pkg::SAT_W;

   typedef logic signed [Q_W-1:0] q_type;

   typedef struct packed {
      logic  valid;
      logic  diag;     // control points on the diagonal: y = x
      logic  done;     // error met tolerance, t is final
      logic  conv;
      logic [bez_pkg::FIELD_W-1:0] xu;
      q_type x;
      q_type t;
      q_type k0;
      q_type k1;
      q_type k2;
      q_type c1y3;
      q_type c2y3;
      q_type h;
      q_type r;
      q_type t2;
      q_type r2;
      q_type acc;
      logic signed [Q_W+1:0] sum;
   } pipe_type;

   logic [bez_pkg::ITER_W-1:0] iter_limit_ff;
   logic [bez_pkg::TOL_W-1:0]  tolerance_ff;
   pipe_type pipe_ff [0:LAST];
   pipe_type pipe_in [0:LAST];
   logic     adv;

   // whole pipe moves unless the output word is held
   assign adv       = !pipe_ff[LAST].valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_limit_ff <= bez_pkg::ITER_LIMIT_RST;
         tolerance_ff  <= bez_pkg::TOLERANCE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            bez_pkg::CSR_ITER_LIMIT: iter_limit_ff <= csr_data[bez_pkg::ITER_W-1:0];
            bez_pkg::CSR_TOLERANCE:  tolerance_ff  <= csr_data[bez_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // entry stage: clamp inputs, polynomial coefficients
   always_comb begin
      logic [bez_pkg::FIELD_W-1:0] xc, c1x, c1y, c2x, c2y;
      logic signed [SAT_W-1:0] c1x_w, c2x_w;
      xc  = bez_pkg::clamp_unit(req_word.x_in);
      c1x = bez_pkg::clamp_unit(req_word.ctrl1_x);
      c1y = bez_pkg::clamp_unit(req_word.ctrl1_y);
      c2x = bez_pkg::clamp_unit(req_word.ctrl2_x);
      c2y = bez_pkg::clamp_unit(req_word.ctrl2_y);
      c1x_w = SAT_W'(c1x);
      c2x_w = SAT_W'(c2x);
      pipe_in[0]       = '0;
      pipe_in[0].valid = req_valid;
      pipe_in[0].diag  = (c1x == c1y) && (c2x == c2y);
      pipe_in[0].xu    = xc;
      pipe_in[0].x     = Q_W'(xc);
      pipe_in[0].t     = Q_W'(xc);
      pipe_in[0].k0    = bez_pkg::sat_q(bez_pkg::ONE_W + 3 * c1x_w - 3 * c2x_w);
      pipe_in[0].k1    = bez_pkg::sat_q(3 * c2x_w - 6 * c1x_w);
      pipe_in[0].k2    = bez_pkg::sat_q(3 * c1x_w);
      pipe_in[0].c1y3  = bez_pkg::sat_q(3 * SAT_W'(c1y));
      pipe_in[0].c2y3  = bez_pkg::sat_q(3 * SAT_W'(c2y));
   end

   // refinement stages: three per iteration, Horner order
   for (genvar gi = 0; gi < bez_pkg::MAX_ITER; gi++) begin : g_iter
      logic act_a, act_b, act_c;
      // each stage decides from the word it holds
      assign act_a = !pipe_ff[3*gi].done   && (bez_pkg::ITER_W'(gi) < iter_limit_ff);
      assign act_b = !pipe_ff[3*gi+1].done && (bez_pkg::ITER_W'(gi) < iter_limit_ff);
      assign act_c = !pipe_ff[3*gi+2].done && (bez_pkg::ITER_W'(gi) < iter_limit_ff);

      always_comb begin
         pipe_in[3*gi+1] = pipe_ff[3*gi];
         if (act_a) begin
            pipe_in[3*gi+1].h = bez_pkg::sat_q(
               SAT_W'(bez_pkg::mul_q(pipe_ff[3*gi].k0, pipe_ff[3*gi].t))
               + SAT_W'(pipe_ff[3*gi].k1));
         end
      end

      always_comb begin
         pipe_in[3*gi+2] = pipe_ff[3*gi+1];
         if (act_b) begin
            pipe_in[3*gi+2].h = bez_pkg::sat_q(
               SAT_W'(bez_pkg::mul_q(pipe_ff[3*gi+1].h, pipe_ff[3*gi+1].t))
               + SAT_W'(pipe_ff[3*gi+1].k2));
         end
      end

      always_comb begin
         q_type ft;
         logic signed [SAT_W-1:0] tol_w;
         tol_w = SAT_W'(tolerance_ff);
         ft = bez_pkg::sat_q(
            SAT_W'(bez_pkg::mul_q(pipe_ff[3*gi+2].h, pipe_ff[3*gi+2].t))
            - SAT_W'(pipe_ff[3*gi+2].x));
         pipe_in[3*gi+3] = pipe_ff[3*gi+2];
         if (act_c) begin
            if (SAT_W'(ft) <= tol_w && SAT_W'(ft) >= -tol_w) begin
               pipe_in[3*gi+3].done = 1'b1;
               pipe_in[3*gi+3].conv = 1'b1;
            end else begin
               pipe_in[3*gi+3].t = bez_pkg::sat_q(
                  SAT_W'(pipe_ff[3*gi+2].t) - SAT_W'(ft >>> 1));
            end
         end
      end
   end

   // y = t^3 + t^2*r*3c2y + t*r^2*3c1y, one product per stage
   always_comb begin
      pipe_in[IT_END+1]    = pipe_ff[IT_END];
      pipe_in[IT_END+1].r  = bez_pkg::sat_q(bez_pkg::ONE_W - SAT_W'(pipe_ff[IT_END].t));
      pipe_in[IT_END+1].t2 = bez_pkg::mul_q(pipe_ff[IT_END].t, pipe_ff[IT_END].t);
   end

   always_comb begin
      pipe_in[IT_END+2]    = pipe_ff[IT_END+1];
      pipe_in[IT_END+2].r2 = bez_pkg::mul_q(pipe_ff[IT_END+1].r, pipe_ff[IT_END+1].r);
   end

   always_comb begin
      pipe_in[IT_END+3]     = pipe_ff[IT_END+2];
      pipe_in[IT_END+3].acc = bez_pkg::mul_q(pipe_ff[IT_END+2].t2, pipe_ff[IT_END+2].t);
   end

   always_comb begin
      pipe_in[IT_END+4]   = pipe_ff[IT_END+3];
      pipe_in[IT_END+4].h = bez_pkg::mul_q(pipe_ff[IT_END+3].t2, pipe_ff[IT_END+3].r);
   end

   always_comb begin
      pipe_in[IT_END+5]     = pipe_ff[IT_END+4];
      pipe_in[IT_END+5].h   = bez_pkg::mul_q(pipe_ff[IT_END+4].h, pipe_ff[IT_END+4].c2y3);
      pipe_in[IT_END+5].sum = (Q_W+2)'(pipe_ff[IT_END+4].acc)
                            + (Q_W+2)'(bez_pkg::mul_q(pipe_ff[IT_END+4].h,
                                                      pipe_ff[IT_END+4].c2y3));
   end

   always_comb begin
      pipe_in[IT_END+6]   = pipe_ff[IT_END+5];
      pipe_in[IT_END+6].h = bez_pkg::mul_q(pipe_ff[IT_END+5].t, pipe_ff[IT_END+5].r2);
   end

   always_comb begin
      pipe_in[IT_END+7]     = pipe_ff[IT_END+6];
      pipe_in[IT_END+7].sum = pipe_ff[IT_END+6].sum
                            + (Q_W+2)'(bez_pkg::mul_q(pipe_ff[IT_END+6].h,
                                                      pipe_ff[IT_END+6].c1y3));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= LAST; s++) pipe_ff[s].valid <= 1'b0;
      end else if (adv) begin
         for (int s = 0; s <= LAST; s++) pipe_ff[s] <= pipe_in[s];
      end
   end

   // saturate y to [0, 1]; diagonal words pass x through
   always_comb begin
      logic signed [Q_W+1:0] ys;
      ys = pipe_ff[LAST].sum;
      rsp_word.converged = pipe_ff[LAST].diag || pipe_ff[LAST].conv;
      if (pipe_ff[LAST].diag)          rsp_word.y_out = pipe_ff[LAST].xu;
      else if (ys < 0)                 rsp_word.y_out = '0;
      else if (ys > (Q_W+2)'(bez_pkg::ONE_U)) rsp_word.y_out = bez_pkg::ONE_U;
      else                             rsp_word.y_out = ys[bez_pkg::FIELD_W-1:0];
   end

   assign rsp_valid = pipe_ff[LAST].valid;

endmodule

FILE: rtl/bez_checker.sv
// Port-level checker for the bezier ease unit, bound to the top level.
// Depends on bez_pkg and bezier_ease_y_from_x_unit_defines.svh.
`include "bezier_ease_y_from_x_unit_defines.svh"

module bez_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input bez_pkg::rsp_word_type rsp_word
);

   `BEZ_ASSERT_RST(a_rst_clears, reset |=> !rsp_valid, "output valid after reset")
   `BEZ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word), "stalled word changed")
   `BEZ_ASSERT(a_y_range, rsp_valid |-> rsp_word.y_out <= bez_pkg::ONE_U, "y above one")
   `BEZ_ASSERT(a_ready_flow, req_ready == (!rsp_valid || rsp_ready), "ready not tied to output stall")

endmodule

bind bezier_ease_y_from_x_unit bez_checker u_bez_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
